/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the bounded list engine.
// Both macros need a clock i_clk; ASSERT_CLK also an active-low reset i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every rising edge, during reset too.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* rtl/ble_pkg.sv */
// Package for the bounded list engine: operation and status codes, cell control type.
// Depends on nothing; used by ble_cell, bounded_list_engine_unit and tb.
`timescale 1ns / 1ps
`default_nettype none

package ble_pkg;

    // Operation codes of a request word.
    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_REAR  = 3'd1;
    localparam logic [2:0] OP_REM_FRONT = 3'd2;
    localparam logic [2:0] OP_REM_REAR  = 3'd3;
    localparam logic [2:0] OP_INS_POS   = 3'd4;

    // Status codes of a result word.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // Broadcast command to every cell of the chain.
    typedef struct packed {
        logic ins;   // open a gap at the slot and write the new word there
        logic pull;  // every cell takes the word of its right neighbor
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/ble_cell.sv */
// One storage cell of the list chain: holds a single word and moves it to its neighbors.
// Depends on ble_pkg for the broadcast command type.
`timescale 1ns / 1ps
`default_nettype none

module ble_cell #(
    parameter int INDEX       = 0,
    parameter int VALUE_WIDTH = 32,
    parameter int CNT_W       = 7
) (
    input  wire                    i_clk,
    input  ble_pkg::t_cell_ctl     i_ctl,
    input  wire  [CNT_W-1:0]       i_slot,
    input  wire  [CNT_W-1:0]       i_rear_slot,
    input  wire  [VALUE_WIDTH-1:0] i_word,
    input  wire  [VALUE_WIDTH-1:0] i_left,
    input  wire  [VALUE_WIDTH-1:0] i_right,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [VALUE_WIDTH-1:0] o_tap
);
    import ble_pkg::*;

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;

    // Insert writes at the slot and shifts everything behind it one place back;
    // a front removal moves every word one place forward.
    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (IDX == i_slot) begin
                n_value = i_word;
            end else if (IDX > i_slot) begin
                n_value = i_left;
            end
        end else if (i_ctl.pull) begin
            n_value = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // The rear cell drives its word onto the shared readout; the others drive zero.
    assign o_value = r_value;
    assign o_tap   = (IDX == i_rear_slot) ? r_value : '0;

endmodule

`default_nettype wire

/* rtl/bounded_list_engine_unit.sv */
// Top level of the bounded list engine: request decode, count, result register.
// Depends on ble_pkg, ble_cell and assert_macros.svh.
//
// Usage: a request word (operation, item, position) enters on i_in_valid/o_in_ready;
// one result word (status, removed_item, removed_valid, entry_count) leaves on
// o_out_valid/i_out_ready for every request. The list lives in a chain of CAPACITY
// cells, entry 0 at the front; inserts and front removals shift the cells in parallel.
// The result is registered at the edge that accepts the request.
// Throughput is one request per cycle unless the receiver stalls, set by the single cell
// update and the count register; the readout of the rear word is one AND-OR select over the cells.
// The input is ready whenever the result register is empty or is being taken in
// the same cycle, so a stalled receiver holds the result and stops new requests.
// Synchronous reset (i_rst_n low) empties the list and drops any pending result;
// the cell contents are not cleared and are never read before being written.
// Inserts into a full list report full; removals from an empty list report empty.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bounded_list_engine_unit #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire  [2:0]        i_operation,
    input  wire signed [31:0] i_item,
    input  wire  [7:0]        i_position,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic [1:0]        o_status,
    output logic signed [31:0] o_removed_item,
    output logic              o_removed_valid,
    output logic [6:0]        o_entry_count
);
    import ble_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic                   in_acc;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_out_valid;
    logic [1:0]             r_status;
    logic [1:0]             n_status;
    logic [31:0]            r_removed;
    logic [31:0]            n_removed;
    logic                   r_rvalid;
    logic                   n_rvalid;
    t_cell_ctl              ctl;
    t_cell_ctl              req_ctl;
    logic [CNT_W-1:0]       slot;
    logic [CNT_W-1:0]       rear_slot;
    logic [VALUE_WIDTH-1:0] word;
    logic [VALUE_WIDTH+31:0] item_ext;
    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       cnt_ext;
    logic [CMP_W-1:0]       pos_m1;
    logic                   full;
    logic                   empty;
    logic                   bad_pos;
    logic [VALUE_WIDTH-1:0] rear_word;
    logic [VALUE_WIDTH+31:0] front_ext;
    logic [VALUE_WIDTH+31:0] rear_ext;
    logic [CNT_W+6:0]       count_ext;
    logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_tap [CAPACITY];

    // Handshake: take a word whenever the result register is free or draining.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // Item sign-extended or truncated to the stored word width.
    assign item_ext = {{VALUE_WIDTH{i_item[31]}}, i_item};
    assign word     = item_ext[VALUE_WIDTH-1:0];

    // Condition checks against the current count.
    assign full      = (r_count >= CAP_C);
    assign empty     = (r_count == '0);
    assign pos_ext   = CMP_W'(i_position);
    assign cnt_ext   = CMP_W'(r_count);
    assign bad_pos   = (pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1));
    assign pos_m1    = pos_ext - CMP_W'(1);
    assign rear_slot = r_count - CNT_W'(1);

    // Removed words are reported masked to 32 bits.
    assign front_ext = {32'd0, cell_val[0]};
    assign rear_ext  = {32'd0, rear_word};

    // Request decode: cell command, new count and result fields.
    always_comb begin
        req_ctl   = '0;
        slot      = '0;
        n_count   = r_count;
        n_status  = ST_OK;
        n_removed = '0;
        n_rvalid  = 1'b0;
        unique case (i_operation)
            OP_INS_FRONT, OP_INS_REAR, OP_INS_POS: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (i_operation == OP_INS_FRONT) begin
                    req_ctl.ins = 1'b1;
                    n_count     = r_count + CNT_W'(1);
                end else if (i_operation == OP_INS_REAR) begin
                    req_ctl.ins = 1'b1;
                    slot        = r_count;
                    n_count     = r_count + CNT_W'(1);
                end else if (bad_pos) begin
                    n_status = ST_BADPOS;
                end else begin
                    req_ctl.ins = 1'b1;
                    slot        = pos_m1[CNT_W-1:0];
                    n_count     = r_count + CNT_W'(1);
                end
            end
            OP_REM_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    req_ctl.pull = 1'b1;
                    n_removed    = front_ext[31:0];
                    n_rvalid     = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                end
            end
            OP_REM_REAR: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_removed = rear_ext[31:0];
                    n_rvalid  = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Cells only move on an accepted request.
    assign ctl = in_acc ? req_ctl : '0;

    // The chain of cells.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_val;
        logic [VALUE_WIDTH-1:0] right_val;

        if (k == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = cell_val[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = cell_val[k+1];
        end

        ble_cell #(
            .INDEX       (k),
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_slot      (slot),
            .i_rear_slot (rear_slot),
            .i_word      (word),
            .i_left      (left_val),
            .i_right     (right_val),
            .o_value     (cell_val[k]),
            .o_tap       (cell_tap[k])
        );
    end

    // Rear readout: only the rear cell drives a nonzero tap.
    always_comb begin
        rear_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rear_word = rear_word | cell_tap[k];
        end
    end

    // Count and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status  <= n_status;
            r_removed <= n_removed;
            r_rvalid  <= n_rvalid;
        end
    end

    // The count only changes together with a new result, so it serves as entry_count.
    assign count_ext       = {7'd0, r_count};
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_item  = r_removed;
    assign o_removed_valid = r_rvalid;
    assign o_entry_count   = count_ext[6:0];

    // Checks on the list bookkeeping.
    `ASSERT_CLK(a_count_bound, r_count <= CAP_C, "entry count above capacity")
    `ASSERT_CLK(a_removed_ok, (o_out_valid && o_removed_valid) |-> (o_status == ST_OK), "removed word with error status")
    `ASSERT_CLK(a_insert_grows, (in_acc && req_ctl.ins) |=> (r_count == $past(r_count) + CNT_W'(1)), "insert did not grow the list")
    `ASSERT_CLK(a_no_move_on_error, (in_acc && (n_status != ST_OK)) |=> (r_count == $past(r_count)), "failed request changed the count")

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for bounded_list_engine_unit: a queue-based list predictor,
// a burst driver, a stalling receiver and a result checker. Depends on ble_pkg and bounded_list_engine_unit.
`timescale 1ns / 1ps

module tb;

    import ble_pkg::*;

    // Sizes and run limits.
    localparam int LIST_CAPACITY = 64;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 500000;

    // Operation codes that the block ignores.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // Extreme words.
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

    // One request word and one result word.
    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] item;
        logic [7:0]         pos;
    } t_list_request;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] removed_word;
        logic               removed_valid;
        logic [6:0]         entry_count;
    } t_list_result;

    // Shape of a stretch of random requests.
    typedef enum int {FILL_UP, DRAIN_DOWN, MIXED, NOISE} t_traffic_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [2:0]        i_operation = '0;
    logic signed [31:0] i_item = '0;
    logic [7:0]        i_position = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [1:0]        o_status;
    logic signed [31:0] o_removed_item;
    logic              o_removed_valid;
    logic [6:0]        o_entry_count;

    t_list_request      pending_requests[$];
    t_list_result       expected_results[$];
    logic signed [31:0] list_contents[$];

    int planned_count = 0;
    int accepted_total = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int burst_left = 1;
    int gap_left = 0;
    int stall_timer = 0;
    int peak_count = 0;
    int status_hits[4] = '{0, 0, 0, 0};
    logic [31:0] stall_pattern = '1;

    bounded_list_engine_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_item          (i_item),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_removed_item  (o_removed_item),
        .o_removed_valid (o_removed_valid),
        .o_entry_count   (o_entry_count)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Applies one request to the list copy and returns the result word it gives.
    function automatic t_list_result apply_request(input t_list_request req);
        t_list_result res;
        res.status = ST_OK;
        res.removed_word = '0;
        res.removed_valid = 1'b0;
        case (req.op)
            OP_INS_FRONT, OP_INS_REAR, OP_INS_POS: begin
                // Fullness wins over a bad position.
                if (list_contents.size() >= LIST_CAPACITY) begin
                    res.status = ST_FULL;
                end else if (req.op == OP_INS_FRONT) begin
                    list_contents.push_front(req.item);
                end else if (req.op == OP_INS_REAR) begin
                    list_contents.push_back(req.item);
                end else if (req.pos == 0 || req.pos > list_contents.size() + 1) begin
                    res.status = ST_BADPOS;
                end else begin
                    list_contents.insert(int'(req.pos) - 1, req.item);
                end
            end
            OP_REM_FRONT: begin
                if (list_contents.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.removed_word = list_contents.pop_front();
                    res.removed_valid = 1'b1;
                end
            end
            OP_REM_REAR: begin
                if (list_contents.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.removed_word = list_contents.pop_back();
                    res.removed_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.entry_count = 7'(list_contents.size());
        return res;
    endfunction

    // Adds a request to the stimulus and tracks the list length it will leave.
    task automatic queue_request(input logic [2:0] op, input logic signed [31:0] word,
                                 input logic [7:0] pos);
        t_list_request req;
        req.op = op;
        req.item = word;
        req.pos = pos;
        pending_requests.push_back(req);
        case (op)
            OP_INS_FRONT, OP_INS_REAR: begin
                if (planned_count < LIST_CAPACITY) planned_count++;
            end
            OP_INS_POS: begin
                if (planned_count < LIST_CAPACITY && pos >= 1 && pos <= planned_count + 1)
                    planned_count++;
            end
            OP_REM_FRONT, OP_REM_REAR: begin
                if (planned_count > 0) planned_count--;
            end
            default: begin
            end
        endcase
    endtask

    // Driver: sends queued requests in bursts and predicts each accepted word.
    always @(posedge i_clk) begin
        t_list_request sent;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                sent.op = i_operation;
                sent.item = i_item;
                sent.pos = i_position;
                expected_results.push_back(apply_request(sent));
                accepted_total++;
                if (list_contents.size() > peak_count) peak_count = list_contents.size();
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    sent = pending_requests.pop_front();
                    i_operation <= sent.op;
                    i_item <= sent.item;
                    i_position <= sent.pos;
                    i_in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // Mostly short bursts, now and then a long unbroken stretch.
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: ready follows a rotating pattern that is redrawn from time to time.
    always @(posedge i_clk) begin
        if (stall_timer == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pattern = '1;
                1: stall_pattern = $urandom | $urandom;
                2: stall_pattern = $urandom & $urandom;
                default: stall_pattern = $urandom;
            endcase
            if (stall_pattern == '0) stall_pattern = 32'h1;
            stall_timer = $urandom_range(32, 200);
        end else begin
            stall_timer--;
        end
        i_out_ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
    end

    // Monitor: compares each taken result word with the oldest prediction.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with no request pending: status %0d count %0d",
                       o_status, o_entry_count);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                status_hits[want.status]++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_removed_item !== want.removed_word) begin
                    $error("removed_item: expected %0d, got %0d",
                           want.removed_word, o_removed_item);
                    mismatch_count++;
                end
                if (o_removed_valid !== want.removed_valid) begin
                    $error("removed_valid: expected %0d, got %0d",
                           want.removed_valid, o_removed_valid);
                    mismatch_count++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, o_entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        t_traffic_mode mode;
        int random_total;
        int round_len;
        int ins_pct;
        int roll;
        logic [2:0] op;
        logic signed [31:0] word;
        logic [7:0] pos;

        // Directed: empty list, position edges, extremes, spare codes, one-entry rear.
        queue_request(OP_REM_FRONT, WORD_MAX, 8'd0);
        queue_request(OP_REM_REAR, WORD_MIN, 8'd255);
        queue_request(OP_INS_POS, 32'sd5, 8'd0);
        queue_request(OP_INS_POS, 32'sd6, 8'd2);
        queue_request(OP_INS_POS, WORD_MAX, 8'd1);
        queue_request(OP_INS_FRONT, WORD_MIN, 8'd0);
        queue_request(OP_INS_REAR, -32'sd1, 8'd0);
        queue_request(OP_INS_POS, 32'sd0, 8'd4);
        queue_request(OP_INS_POS, 32'sd7, 8'd255);
        queue_request(OP_INS_POS, 32'sh5555_5555, 8'd2);
        queue_request(OP_INS_FRONT, 32'shAAAA_AAAA, 8'd255);
        queue_request(OP_SPARE_FIRST, $urandom, 8'd255);
        queue_request(OP_SPARE_FIRST + 3'd1, $urandom, 8'd1);
        queue_request(OP_SPARE_LAST, $urandom, 8'd0);
        queue_request(OP_REM_FRONT, 32'sd0, 8'd0);
        queue_request(OP_REM_REAR, 32'sd0, 8'd0);
        queue_request(OP_REM_FRONT, 32'sd0, 8'd0);
        queue_request(OP_REM_REAR, 32'sd0, 8'd0);
        queue_request(OP_REM_FRONT, 32'sd0, 8'd0);
        queue_request(OP_REM_REAR, 32'sd0, 8'd0);
        queue_request(OP_REM_REAR, 32'sd0, 8'd0);
        queue_request(OP_INS_REAR, 32'sd1, 8'd0);
        queue_request(OP_REM_REAR, 32'sd0, 8'd0);
        queue_request(OP_REM_FRONT, 32'sd0, 8'd0);

        // Random: stretches that fill, drain, mix or throw noise at the list.
        random_total = 0;
        while (random_total < RANDOM_ITEMS) begin
            mode = t_traffic_mode'($urandom_range(0, 3));
            round_len = $urandom_range(20, 120);
            ins_pct = (mode == FILL_UP) ? 85 : (mode == DRAIN_DOWN) ? 15 : 50;
            for (int k = 0; k < round_len; k++) begin
                case ($urandom_range(0, 9))
                    0: word = WORD_MAX;
                    1: word = WORD_MIN;
                    2: word = '0;
                    3: word = -32'sd1;
                    default: word = $urandom;
                endcase
                pos = 8'($urandom_range(0, 255));
                roll = $urandom_range(0, 99);
                if (mode == NOISE) begin
                    op = 3'($urandom_range(0, 7));
                end else if (roll >= 98) begin
                    op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
                end else if (roll < ins_pct) begin
                    case ($urandom_range(0, 2))
                        0: op = OP_INS_FRONT;
                        1: op = OP_INS_REAR;
                        default: op = OP_INS_POS;
                    endcase
                end else begin
                    op = $urandom_range(0, 1) ? OP_REM_FRONT : OP_REM_REAR;
                end
                // Positioned inserts mostly land in the list or at its end, sometimes at zero or past it.
                if (mode != NOISE && op == OP_INS_POS) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70) pos = 8'($urandom_range(1, planned_count + 1));
                    else if (roll < 80) pos = 8'(planned_count + 1);
                    else if (roll < 90) pos = 8'd0;
                    else pos = 8'($urandom_range(planned_count + 2, 255));
                end
                queue_request(op, word, pos);
                random_total++;
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go out and every result to come back.
        while (pending_requests.size() > 0 || i_in_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d requests checked; ok %0d, empty %0d, bad position %0d, full %0d",
                 accepted_total, status_hits[ST_OK], status_hits[ST_EMPTY],
                 status_hits[ST_BADPOS], status_hits[ST_FULL]);
        $display("tb: deepest list %0d entries, %0d mismatches", peak_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ble_pkg.sv
rtl/ble_cell.sv
rtl/bounded_list_engine_unit.sv
verif/tb.sv
